/* design/val_pkg.sv */
package val_pkg;

   // fixed field widths
   localparam int SPEED_W    = 15;
   localparam int ACCEL_W    = 16;
   localparam int DT_W       = 18;
   localparam int DT_MAG_W   = 17;
   localparam int STEP_W     = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // one second in elapsed-time units
   localparam logic [DT_W-1:0] DT_ONE_SEC = 18'd65536;

   // register reset values
   localparam logic [SPEED_W-1:0] LIN_SPEED_RST = 15'd1024;
   localparam logic [SPEED_W-1:0] ANG_SPEED_RST = 15'd1024;
   localparam logic [ACCEL_W-1:0] LIN_ACCEL_RST = 16'd512;
   localparam logic [ACCEL_W-1:0] ANG_ACCEL_RST = 16'd1024;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      CSR_LIN_SPEED = 2'd0,
      CSR_ANG_SPEED = 2'd1,
      CSR_LIN_ACCEL = 2'd2,
      CSR_ANG_ACCEL = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [SPEED_W-1:0] lin_speed;
      logic [SPEED_W-1:0] ang_speed;
      logic [ACCEL_W-1:0] lin_accel;
      logic [ACCEL_W-1:0] ang_accel;
   } cfg_type;

   // pipeline load enables
   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic out_load;
   } pipe_ctl_type;

endpackage

/* design/val_req_if.sv */
interface val_req_if #(
   parameter int VEL_WIDTH = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [VEL_WIDTH-1:0]  raw_vx;
   logic signed [VEL_WIDTH-1:0]  raw_vy;
   logic signed [VEL_WIDTH-1:0]  raw_wz;
   logic signed [val_pkg::DT_W-1:0] elapsed;

   modport source (output valid, raw_vx, raw_vy, raw_wz, elapsed, input ready);
   modport sink   (input valid, raw_vx, raw_vy, raw_wz, elapsed, output ready);
endinterface

/* design/val_rsp_if.sv */
interface val_rsp_if #(
   parameter int VEL_WIDTH = 16
) ();
   logic                        valid;
   logic                        ready;
   logic signed [VEL_WIDTH-1:0] out_vx;
   logic signed [VEL_WIDTH-1:0] out_vy;
   logic signed [VEL_WIDTH-1:0] out_wz;

   modport source (output valid, out_vx, out_vy, out_wz, input ready);
   modport sink   (input valid, out_vx, out_vy, out_wz, output ready);
endinterface

/* design/val_csr.sv */
module val_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [val_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [val_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [val_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output val_pkg::cfg_type                  cfg
);

   logic [val_pkg::SPEED_W-1:0] lin_speed_ff, lin_speed_in;
   logic [val_pkg::SPEED_W-1:0] ang_speed_ff, ang_speed_in;
   logic [val_pkg::ACCEL_W-1:0] lin_accel_ff, lin_accel_in;
   logic [val_pkg::ACCEL_W-1:0] ang_accel_ff, ang_accel_in;
   logic                        wr_en;
   val_pkg::csr_idx_type        idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = val_pkg::csr_idx_type'(csr_paddr[3:2]);

   // register write decode
   always_comb begin
      lin_speed_in = lin_speed_ff;
      ang_speed_in = ang_speed_ff;
      lin_accel_in = lin_accel_ff;
      ang_accel_in = ang_accel_ff;
      if (wr_en) begin
         case (idx)
            val_pkg::CSR_LIN_SPEED: lin_speed_in = csr_pwdata[val_pkg::SPEED_W-1:0];
            val_pkg::CSR_ANG_SPEED: ang_speed_in = csr_pwdata[val_pkg::SPEED_W-1:0];
            val_pkg::CSR_LIN_ACCEL: lin_accel_in = csr_pwdata[val_pkg::ACCEL_W-1:0];
            val_pkg::CSR_ANG_ACCEL: ang_accel_in = csr_pwdata[val_pkg::ACCEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_speed_ff <= val_pkg::LIN_SPEED_RST;
         ang_speed_ff <= val_pkg::ANG_SPEED_RST;
         lin_accel_ff <= val_pkg::LIN_ACCEL_RST;
         ang_accel_ff <= val_pkg::ANG_ACCEL_RST;
      end else begin
         lin_speed_ff <= lin_speed_in;
         ang_speed_ff <= ang_speed_in;
         lin_accel_ff <= lin_accel_in;
         ang_accel_ff <= ang_accel_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         val_pkg::CSR_LIN_SPEED: csr_prdata = val_pkg::CSR_DATA_W'(lin_speed_ff);
         val_pkg::CSR_ANG_SPEED: csr_prdata = val_pkg::CSR_DATA_W'(ang_speed_ff);
         val_pkg::CSR_LIN_ACCEL: csr_prdata = val_pkg::CSR_DATA_W'(lin_accel_ff);
         val_pkg::CSR_ANG_ACCEL: csr_prdata = val_pkg::CSR_DATA_W'(ang_accel_ff);
         default:                csr_prdata = '0;
      endcase
   end

   assign cfg.lin_speed = lin_speed_ff;
   assign cfg.ang_speed = ang_speed_ff;
   assign cfg.lin_accel = lin_accel_ff;
   assign cfg.ang_accel = ang_accel_ff;

endmodule

/* design/val_ctrl.sv */
module val_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output val_pkg::pipe_ctl_type ctl
);

   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in;
   logic out_v_ff, out_v_in;

   // a stage moves on when the one after it is empty or drains this cycle
   always_comb begin
      ctl.out_load = s2_v_ff & (~out_v_ff | rsp_ready);
      ctl.s2_load  = s1_v_ff & (~s2_v_ff | ctl.out_load);
      req_ready    = ~s1_v_ff | ctl.s2_load;
      ctl.s1_load  = req_valid & req_ready;
   end

   // stage occupancy
   always_comb begin
      s1_v_in  = ctl.s1_load  | (s1_v_ff & ~ctl.s2_load);
      s2_v_in  = ctl.s2_load  | (s2_v_ff & ~ctl.out_load);
      out_v_in = ctl.out_load | (out_v_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_valid = out_v_ff;

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && s2_v_ff && out_v_ff && !rsp_ready) |-> !req_ready)
      else $error("beat taken with the pipeline full and stalled");

   a_out_follows: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |=> out_v_ff)
      else $error("result register loaded but not shown valid");

   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && !ctl.out_load) |=> s2_v_ff)
      else $error("stage two item lost while stalled");

endmodule

/* design/val_axis.sv */
module val_axis #(
   parameter int VEL_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  val_pkg::pipe_ctl_type               ctl,
   input  logic signed [VEL_WIDTH-1:0]         raw,
   input  logic [val_pkg::DT_MAG_W-1:0]        dt,
   input  logic                                rate_en,
   input  logic [val_pkg::SPEED_W-1:0]         speed_lim,
   input  logic [val_pkg::ACCEL_W-1:0]         accel,
   output logic signed [VEL_WIDTH-1:0]         result
);

   localparam int LimW  = (VEL_WIDTH > 16) ? VEL_WIDTH : 16;
   localparam int MathW = LimW + 2;
   localparam int ProdW = val_pkg::ACCEL_W + val_pkg::DT_MAG_W;
   localparam logic [LimW-1:0] TopLim = LimW'((64'd1 << (VEL_WIDTH - 1)) - 64'd1);

   logic [LimW-1:0]                  lim_wide;
   logic signed [VEL_WIDTH-1:0]      vlim;
   logic signed [VEL_WIDTH-1:0]      neg_vlim;
   logic signed [VEL_WIDTH-1:0]      v_clamp;
   logic [ProdW-1:0]                 prod;
   logic signed [VEL_WIDTH-1:0]      v_ff;
   logic [val_pkg::STEP_W-1:0]       maxd_ff;
   logic                             rate_en_ff;
   logic signed [MathW-1:0]          v_w, prev_w, maxd_w, diff_w, vlim_w;
   logic signed [MathW-1:0]          stepped, clamped;
   logic signed [VEL_WIDTH-1:0]      res_ff, res_in;

   // speed limit saturated to the velocity range
   always_comb begin
      lim_wide = (LimW'(speed_lim) > TopLim) ? TopLim : LimW'(speed_lim);
      vlim     = $signed(lim_wide[VEL_WIDTH-1:0]);
      neg_vlim = -vlim;
   end

   // stage one: speed clamp and step budget
   always_comb begin
      if (raw > vlim)
         v_clamp = vlim;
      else if (raw < neg_vlim)
         v_clamp = neg_vlim;
      else
         v_clamp = raw;
      prod = ProdW'(accel) * ProdW'(dt);
   end

   always_ff @(posedge clock) begin
      if (ctl.s2_load) begin
         v_ff       <= v_clamp;
         maxd_ff    <= prod[val_pkg::STEP_W+15:16];
         rate_en_ff <= rate_en;
      end
   end

   // stage two: limit change from previous output, then clamp again
   always_comb begin
      v_w     = MathW'(v_ff);
      prev_w  = MathW'(res_ff);
      maxd_w  = $signed(MathW'(maxd_ff));
      vlim_w  = MathW'(vlim);
      diff_w  = v_w - prev_w;
      stepped = v_w;
      if (rate_en_ff) begin
         if (diff_w > maxd_w)
            stepped = prev_w + maxd_w;
         else if (diff_w < -maxd_w)
            stepped = prev_w - maxd_w;
      end
      if (stepped > vlim_w)
         clamped = vlim_w;
      else if (stepped < -vlim_w)
         clamped = -vlim_w;
      else
         clamped = stepped;
      res_in = $signed(clamped[VEL_WIDTH-1:0]);
   end

   // result register doubles as the previous output
   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else if (ctl.out_load) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

   a_no_rate_passthru: assert property (@(posedge clock) disable iff (reset)
      (ctl.out_load && !rate_en_ff) |=> (res_ff == $past(v_ff)))
      else $error("speed-clamped value altered with rate limiting off");

endmodule

/* design/velocity_accel_limiter.sv */
// An accepted request beat passes the input, budget and result registers.
// Throughput: one beat per cycle unless the result side stalls; the
// previous-output feedback closes within the final stage, so back-to-back
// requests never wait on each other.
// Reset (synchronous, active high): pipeline emptied, previous outputs zero,
// limits back to 1024 / 1024 / 512 / 1024.
module velocity_accel_limiter #(
   parameter int VEL_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   val_req_if.sink                        req_bus,
   val_rsp_if.source                      rsp_bus,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [val_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [val_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [val_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   val_pkg::cfg_type                   cfg;
   val_pkg::pipe_ctl_type              ctl;
   logic signed [VEL_WIDTH-1:0]        vx_ff, vy_ff, wz_ff;
   logic [val_pkg::DT_MAG_W-1:0]       dt_ff, dt_in;
   logic                               rate_en_ff, rate_en_in;

   val_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   val_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctl       (ctl)
   );

   // elapsed time outside (0, 1 s] disables rate limiting
   always_comb begin
      rate_en_in = ~req_bus.elapsed[val_pkg::DT_W-1]
                 & ($unsigned(req_bus.elapsed) <= val_pkg::DT_ONE_SEC)
                 & (req_bus.elapsed != '0);
      dt_in      = req_bus.elapsed[val_pkg::DT_MAG_W-1:0];
   end

   // input register
   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         vx_ff      <= req_bus.raw_vx;
         vy_ff      <= req_bus.raw_vy;
         wz_ff      <= req_bus.raw_wz;
         dt_ff      <= dt_in;
         rate_en_ff <= rate_en_in;
      end
   end

   val_axis #(.VEL_WIDTH(VEL_WIDTH)) u_axis_vx (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .raw       (vx_ff),
      .dt        (dt_ff),
      .rate_en   (rate_en_ff),
      .speed_lim (cfg.lin_speed),
      .accel     (cfg.lin_accel),
      .result    (rsp_bus.out_vx)
   );

   val_axis #(.VEL_WIDTH(VEL_WIDTH)) u_axis_vy (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .raw       (vy_ff),
      .dt        (dt_ff),
      .rate_en   (rate_en_ff),
      .speed_lim (cfg.lin_speed),
      .accel     (cfg.lin_accel),
      .result    (rsp_bus.out_vy)
   );

   val_axis #(.VEL_WIDTH(VEL_WIDTH)) u_axis_wz (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .raw       (wz_ff),
      .dt        (dt_ff),
      .rate_en   (rate_en_ff),
      .speed_lim (cfg.ang_speed),
      .accel     (cfg.ang_accel),
      .result    (rsp_bus.out_wz)
   );

endmodule

/* sim/velocity_accel_limiter_tb.sv */
`timescale 1ns / 100ps

module velocity_accel_limiter_tb;

   localparam int VW              = 16;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASE_ITEMS     = 250;

   typedef struct {
      logic signed [VW-1:0]            vx;
      logic signed [VW-1:0]            vy;
      logic signed [VW-1:0]            wz;
      logic signed [val_pkg::DT_W-1:0] dt;
   } motion_cmd_type;

   typedef struct {
      logic signed [VW-1:0] vx;
      logic signed [VW-1:0] vy;
      logic signed [VW-1:0] wz;
   } motion_vel_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [val_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [val_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [val_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   val_req_if #(.VEL_WIDTH(VW)) req_bus ();
   val_rsp_if #(.VEL_WIDTH(VW)) rsp_bus ();

   velocity_accel_limiter #(.VEL_WIDTH(VW)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // limiter state as the block should hold it
   logic [val_pkg::SPEED_W-1:0] lin_speed_lim;
   logic [val_pkg::SPEED_W-1:0] ang_speed_lim;
   logic [val_pkg::ACCEL_W-1:0] lin_accel_lim;
   logic [val_pkg::ACCEL_W-1:0] ang_accel_lim;
   logic signed [VW-1:0]        held_vx;
   logic signed [VW-1:0]        held_vy;
   logic signed [VW-1:0]        held_wz;

   motion_vel_type expected_vel_q[$];
   int             fail_count    = 0;
   int             hold_off_reqs = 0;
   int             burst_left    = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("velocity_accel_limiter test failed");
      $finish;
   end

   // one axis: speed clamp, slew limit against the held value, clamp again
   function automatic logic signed [VW-1:0] slew_axis(
         input logic signed [VW-1:0]        raw,
         input logic signed [VW-1:0]        prev,
         input logic [val_pkg::SPEED_W-1:0] vlim,
         input logic [val_pkg::ACCEL_W-1:0] accel,
         input int                          dt);
      longint lim;
      longint v;
      longint maxd;
      longint d;
      lim = vlim;
      v   = raw;
      if (v > lim) v = lim;
      else if (v < -lim) v = -lim;
      if (dt > 0) begin
         maxd = (longint'(accel) * dt) >>> 16;
         d    = v - longint'(prev);
         if (d > maxd) v = longint'(prev) + maxd;
         else if (d < -maxd) v = longint'(prev) - maxd;
      end
      if (v > lim) v = lim;
      else if (v < -lim) v = -lim;
      return v[VW-1:0];
   endfunction

   // next limited velocity; also moves the held outputs on
   function automatic motion_vel_type advance_motion(input motion_cmd_type cmd);
      motion_vel_type res;
      int             dt;
      dt = cmd.dt;
      // negative or longer than one second counts as no time at all
      if (dt < 0 || dt > 65536) dt = 0;
      res.vx  = slew_axis(cmd.vx, held_vx, lin_speed_lim, lin_accel_lim, dt);
      res.vy  = slew_axis(cmd.vy, held_vy, lin_speed_lim, lin_accel_lim, dt);
      res.wz  = slew_axis(cmd.wz, held_wz, ang_speed_lim, ang_accel_lim, dt);
      held_vx = res.vx;
      held_vy = res.vy;
      held_wz = res.wz;
      return res;
   endfunction

   function automatic logic [val_pkg::CSR_DATA_W-1:0] limit_reg_value(
         input val_pkg::csr_idx_type idx);
      case (idx)
         val_pkg::CSR_LIN_SPEED: return val_pkg::CSR_DATA_W'(lin_speed_lim);
         val_pkg::CSR_ANG_SPEED: return val_pkg::CSR_DATA_W'(ang_speed_lim);
         val_pkg::CSR_LIN_ACCEL: return val_pkg::CSR_DATA_W'(lin_accel_lim);
         default:                return val_pkg::CSR_DATA_W'(ang_accel_lim);
      endcase
   endfunction

   function automatic logic signed [VW-1:0] rand_vel(input logic [val_pkg::SPEED_W-1:0] lim);
      int span;
      span = int'(lim) + int'(lim) / 8 + 1;
      if (span > 32767) span = 32767;
      case ($urandom_range(0, 9))
         0: return VW'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0:       return VW'(16'h8000);
               1:       return VW'(16'h7FFF);
               2:       return VW'(lim);
               default: return VW'(-int'(lim));
            endcase
         end
         default: return VW'(int'($urandom_range(0, 2 * span)) - span);
      endcase
   endfunction

   // mostly valid time steps, short ones favoured so the slew limit bites
   function automatic logic signed [val_pkg::DT_W-1:0] rand_elapsed();
      case ($urandom_range(0, 19))
         0, 1:    return val_pkg::DT_W'(-int'($urandom_range(1, 131072)));
         2, 3:    return val_pkg::DT_W'($urandom_range(65537, 131071));
         4:       return '0;
         5:       return val_pkg::DT_W'(65536);
         6, 7, 8, 9, 10, 11, 12: return val_pkg::DT_W'($urandom_range(1, 2048));
         default: return val_pkg::DT_W'($urandom_range(1, 65536));
      endcase
   endfunction

   function automatic motion_cmd_type rand_cmd();
      motion_cmd_type cmd;
      cmd.vx = rand_vel(lin_speed_lim);
      cmd.vy = rand_vel(lin_speed_lim);
      cmd.wz = rand_vel(ang_speed_lim);
      cmd.dt = rand_elapsed();
      return cmd;
   endfunction

   // offer one command beat and wait until it is taken
   task automatic send_cmd(input motion_cmd_type cmd);
      req_bus.valid   <= 1'b1;
      req_bus.raw_vx  <= cmd.vx;
      req_bus.raw_vy  <= cmd.vy;
      req_bus.raw_wz  <= cmd.wz;
      req_bus.elapsed <= cmd.dt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_vel_q.push_back(advance_motion(cmd));
   endtask

   task automatic send_vel(input int vx, input int vy, input int wz, input int dt);
      motion_cmd_type cmd;
      cmd.vx = VW'(vx);
      cmd.vy = VW'(vy);
      cmd.wz = VW'(wz);
      cmd.dt = val_pkg::DT_W'(dt);
      send_cmd(cmd);
   endtask

   // bursts of random length separated by random gaps
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
   endtask

   task automatic send_random_cmds(input int count, input bit paced);
      for (int i = 0; i < count; i++) begin
         if (paced) pace_sender();
         send_cmd(rand_cmd());
      end
   endtask

   // stop offering and let every outstanding result come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_vel_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input val_pkg::csr_idx_type idx,
                            input logic [val_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= val_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         val_pkg::CSR_LIN_SPEED: lin_speed_lim = data[val_pkg::SPEED_W-1:0];
         val_pkg::CSR_ANG_SPEED: ang_speed_lim = data[val_pkg::SPEED_W-1:0];
         val_pkg::CSR_LIN_ACCEL: lin_accel_lim = data[val_pkg::ACCEL_W-1:0];
         default:                ang_accel_lim = data[val_pkg::ACCEL_W-1:0];
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input val_pkg::csr_idx_type idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= val_pkg::CSR_ADDR_W'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== limit_reg_value(idx)) begin
         $error("%s mismatch: expected %0d, actual %0d", idx.name(), limit_reg_value(idx),
                csr_prdata);
         fail_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // program all four limits; upper bits carry junk that must be dropped
   task automatic load_limits(input int lin_s, input int ang_s, input int lin_a,
                              input int ang_a);
      logic [val_pkg::CSR_DATA_W-1:0] junk;
      wait_idle();
      junk = $urandom;
      csr_write(val_pkg::CSR_LIN_SPEED,
                {junk[31:val_pkg::SPEED_W], val_pkg::SPEED_W'(lin_s)});
      junk = $urandom;
      csr_write(val_pkg::CSR_ANG_SPEED,
                {junk[31:val_pkg::SPEED_W], val_pkg::SPEED_W'(ang_s)});
      junk = $urandom;
      csr_write(val_pkg::CSR_LIN_ACCEL,
                {junk[31:val_pkg::ACCEL_W], val_pkg::ACCEL_W'(lin_a)});
      junk = $urandom;
      csr_write(val_pkg::CSR_ANG_ACCEL,
                {junk[31:val_pkg::ACCEL_W], val_pkg::ACCEL_W'(ang_a)});
      csr_read_check(val_pkg::CSR_LIN_SPEED);
      csr_read_check(val_pkg::CSR_ANG_SPEED);
      csr_read_check(val_pkg::CSR_LIN_ACCEL);
      csr_read_check(val_pkg::CSR_ANG_ACCEL);
   endtask

   // limits after reset, then a few commands against them
   task automatic test_reset_values();
      csr_read_check(val_pkg::CSR_LIN_SPEED);
      csr_read_check(val_pkg::CSR_ANG_SPEED);
      csr_read_check(val_pkg::CSR_LIN_ACCEL);
      csr_read_check(val_pkg::CSR_ANG_ACCEL);
      send_vel(300, -300, 700, 65536);
      send_vel(32767, -32768, 32767, 65536);
      send_vel(-32768, 32767, -32768, 65536);
   endtask

   // field extremes and the time-step corner cases
   task automatic test_directed_corners();
      // tiny step: budget floors to zero, outputs hold
      send_vel(1000, 1000, 1000, 1);
      // negative, over-long and zero time: speed clamp only
      send_vel(0, 0, 0, -1);
      send_vel(-32768, -32768, -32768, 131071);
      send_vel(-1, 1, -1, 65537);
      send_vel(5, -5, 5, -131072);
      send_vel(100, -100, 300, 0);
      // exactly one second is still a valid step
      send_vel(-32768, 32767, 32767, 65536);
      // widest limits
      load_limits(32767, 32767, 65535, 65535);
      send_vel(32767, -32768, 32767, 65536);
      send_vel(-32768, 32767, -32768, 128);
      send_vel(-32768, 32767, -32768, 65536);
      send_vel(0, 0, 0, 1);
      send_vel(-32768, -32768, 32767, 0);
      // zero limits force everything to zero
      load_limits(0, 0, 0, 0);
      send_vel(32767, -32768, 12345, 65536);
      send_vel(-32768, 32767, -1, 0);
      // full speed but no slew allowed: held values stay put, except on a zero time step
      load_limits(32767, 32767, 0, 0);
      send_vel(32767, -32768, 32767, 65536);
      send_vel(0, 0, 0, 0);
      send_vel(-32768, 32767, -32768, 40000);
      send_vel(1, -1, 1, 1);
   endtask

   // several limit settings, random commands under each
   task automatic test_random_settings();
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: load_limits(val_pkg::LIN_SPEED_RST, val_pkg::ANG_SPEED_RST,
                           val_pkg::LIN_ACCEL_RST, val_pkg::ANG_ACCEL_RST);
            1: load_limits(32767, 32767, 65535, 65535);
            2: load_limits(1, 32767, 1, 65535);
            3: load_limits(20000, 500, 300, 40000);
            4: load_limits(32767, 0, 65535, 1);
            default: load_limits($urandom_range(0, 32767), $urandom_range(0, 32767),
                                 $urandom_range(0, 65535), $urandom_range(0, 65535));
         endcase
         send_random_cmds(PHASE_ITEMS, 1'b1);
      end
   endtask

   // receiver holds off for a long stretch while commands keep coming
   task automatic test_result_backpressure();
      load_limits($urandom_range(100, 32767), $urandom_range(100, 32767),
                  $urandom_range(0, 65535), $urandom_range(0, 65535));
      hold_off_reqs++;
      send_random_cmds(120, 1'b0);
   endtask

   // sender pauses until every result is back, then carries on
   task automatic test_drain_pause();
      send_random_cmds(30, 1'b1);
      req_bus.valid <= 1'b0;
      while (expected_vel_q.size() != 0) @(posedge clock);
      send_random_cmds(30, 1'b1);
   endtask

   // result side: compare each beat, then pick the next ready value
   initial begin : rsp_sink
      int             mode      = 0;
      int             mode_left = 0;
      int             hold_left = 0;
      int             hold_seen = 0;
      logic [7:0]     pattern   = 8'b1011_0010;
      motion_vel_type exp_vel;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_vel_q.size() == 0) begin
               $error("result beat with nothing expected: vx %0d vy %0d wz %0d",
                      rsp_bus.out_vx, rsp_bus.out_vy, rsp_bus.out_wz);
               fail_count++;
            end else begin
               exp_vel = expected_vel_q.pop_front();
               if (rsp_bus.out_vx !== exp_vel.vx) begin
                  $error("out_vx mismatch: expected %0d, actual %0d", exp_vel.vx,
                         rsp_bus.out_vx);
                  fail_count++;
               end
               if (rsp_bus.out_vy !== exp_vel.vy) begin
                  $error("out_vy mismatch: expected %0d, actual %0d", exp_vel.vy,
                         rsp_bus.out_vy);
                  fail_count++;
               end
               if (rsp_bus.out_wz !== exp_vel.wz) begin
                  $error("out_wz mismatch: expected %0d, actual %0d", exp_vel.wz,
                         rsp_bus.out_wz);
                  fail_count++;
               end
            end
         end
         // a long hold-off was asked for
         if (hold_off_reqs != hold_seen) begin
            hold_seen = hold_off_reqs;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         pattern = {pattern[6:0], pattern[7]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_bus.ready <= pattern[0];
            endcase
         end
      end
   end

   // main sequence
   initial begin
      lin_speed_lim = val_pkg::LIN_SPEED_RST;
      ang_speed_lim = val_pkg::ANG_SPEED_RST;
      lin_accel_lim = val_pkg::LIN_ACCEL_RST;
      ang_accel_lim = val_pkg::ANG_ACCEL_RST;
      held_vx       = '0;
      held_vy       = '0;
      held_wz       = '0;
      reset           <= 1'b1;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.raw_vx  <= '0;
      req_bus.raw_vy  <= '0;
      req_bus.raw_wz  <= '0;
      req_bus.elapsed <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_values();
      test_directed_corners();
      test_random_settings();
      test_result_backpressure();
      test_drain_pause();

      wait_idle();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("velocity_accel_limiter test passed");
      end else begin
         $display("velocity_accel_limiter test failed");
      end
      $finish;
   end

endmodule
